// ----- hdl/sbh_pkg.sv -----
// Shared types and constants for the SHA-1 byte stream hasher.
// Holds the sequencer state type, initial chaining words and round constants.
// No dependencies.
`timescale 1ns / 1ps

package sbh_pkg;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUT
   } state_type;

   typedef logic [31:0] word_type;

   localparam int unsigned NUM_WORDS   = 5;
   localparam int unsigned NUM_ROUNDS  = 80;
   localparam int unsigned BLOCK_BYTES = 64;

   // Initial chaining words h0..h4
   localparam word_type H_INIT [NUM_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // Round constants, one per group of twenty rounds
   localparam word_type K_R00 = 32'h5A827999;
   localparam word_type K_R20 = 32'h6ED9EBA1;
   localparam word_type K_R40 = 32'h8F1BBCDC;
   localparam word_type K_R60 = 32'hCA62C1D6;

   // First padding byte after the message
   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Fill position where the big-endian length begins
   localparam logic [5:0] LEN_START = 6'(BLOCK_BYTES - 8);

   function automatic word_type rol32(input word_type x, input int unsigned n);
      rol32 = (x << n) | (x >> (32 - n));
   endfunction

endpackage

// ----- hdl/sha1_byte_stream_hasher.sv -----
// SHA-1 byte stream hasher: byte intake, padding sequencer and round unit.
// Depends on sbh_pkg for the state type, initial words and round constants.
`timescale 1ns / 1ps

// Usage
//   req_*: one message byte per item in tdata[7:0]; tlast marks the final item
//   of the message, tuser set means the item carries no byte (with tlast it
//   closes an empty message; without tlast the item is dropped).
//   rsp_*: five items per message, the digest words h0..h4, index in tuser,
//   tlast on h4.
// Timing
//   A byte that neither completes a 64-byte block nor ends the message leaves
//   req_tready high for the next item. A byte that completes a block starts the
//   shared round unit: 80 rounds, one per cycle, then a fold into the chaining
//   words (ST_UPDATE), and req_tready stays low through both.
//   After the last item the padding bytes are fed in one per cycle through the
//   same byte path (up to 64 bytes, or up to 72 when a second block is needed),
//   pausing while each full block is hashed, then the five words are presented.
// Reset and stall
//   reset returns the chaining words, bit count and fill position to their
//   initial values. While rsp_tready is low the current word holds and no
//   input item is taken; after h4 is taken the block is ready for a new message.
module sha1_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // is_last
   input  logic        req_tuser,   // no_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast,   // last_word
   output logic [2:0]  rsp_tuser    // [2:0] word_index
);
   import sbh_pkg::*;

   state_type     state_ff, state_in;
   logic [5:0]    pos_ff, pos_in;
   logic [63:0]   bit_count_ff, bit_count_in;
   logic [511:0]  msg_ff, msg_in;
   word_type      h_ff [NUM_WORDS];
   word_type      h_in [NUM_WORDS];
   word_type      a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type      a_in, b_in, c_in, d_in, e_in;
   logic [6:0]    round_ff, round_in;
   logic          pad_ff, pad_in;
   logic          first_ff, first_in;
   logic          len_ff, len_in;
   logic [2:0]    word_ff, word_in;

   logic          wr_en;
   logic [7:0]    wr_byte;
   word_type      f_val, k_val, w_cur, w_new, t_val;

   // Round unit: message schedule taps and round function
   always_comb begin
      w_cur = msg_ff[511:480];
      w_new = rol32(msg_ff[95:64] ^ msg_ff[255:224] ^ msg_ff[447:416] ^ msg_ff[511:480], 1);
      priority if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_R00;
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_R20;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_R40;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_R60;
      end
      t_val = rol32(a_ff, 5) + f_val + e_ff + k_val + w_cur;
   end

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      bit_count_in = bit_count_ff;
      msg_in       = msg_ff;
      h_in         = h_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      round_in     = round_ff;
      pad_in       = pad_ff;
      first_in     = first_ff;
      len_in       = len_ff;
      word_in      = word_ff;
      wr_en        = 1'b0;
      wr_byte      = req_tdata;
      req_tready   = (state_ff == ST_IDLE);
      rsp_tvalid   = (state_ff == ST_OUT);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_tuser) begin
                  wr_en        = 1'b1;
                  bit_count_in = bit_count_ff + 64'd8;
               end
               if (req_tlast) begin
                  pad_in   = 1'b1;
                  first_in = 1'b1;
               end
               if (!req_tuser && pos_ff == 6'd63) begin
                  state_in = ST_ROUND;
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // feed pad marker, zero fill, then length bytes high first
            wr_en = 1'b1;
            if (first_ff) begin
               wr_byte  = PAD_BYTE;
               first_in = 1'b0;
            end else if (len_ff) begin
               wr_byte      = bit_count_ff[63:56];
               bit_count_in = {bit_count_ff[55:0], 8'h00};
            end else begin
               wr_byte = 8'h00;
            end
            if (pos_ff == LEN_START - 6'd1) begin
               len_in = 1'b1;
            end
            if (pos_ff == 6'd63) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            a_in     = t_val;
            b_in     = a_ff;
            c_in     = rol32(b_ff, 30);
            d_in     = c_ff;
            e_in     = d_ff;
            msg_in   = {msg_ff[479:0], w_new};
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(NUM_ROUNDS - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            h_in[0]  = h_ff[0] + a_ff;
            h_in[1]  = h_ff[1] + b_ff;
            h_in[2]  = h_ff[2] + c_ff;
            h_in[3]  = h_ff[3] + d_ff;
            h_in[4]  = h_ff[4] + e_ff;
            round_in = '0;
            priority if (pad_ff && len_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == 3'(NUM_WORDS - 1)) begin
                  // message done: back to initial state
                  state_in     = ST_IDLE;
                  h_in         = H_INIT;
                  bit_count_in = '0;
                  pos_in       = '0;
                  pad_in       = 1'b0;
                  first_in     = 1'b0;
                  len_in       = 1'b0;
                  word_in      = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Shift a byte into the block; a full block loads the working words
      if (wr_en) begin
         msg_in = {msg_ff[503:0], wr_byte};
         pos_in = pos_ff + 6'd1;
         if (pos_ff == 6'd63) begin
            a_in     = h_ff[0];
            b_in     = h_ff[1];
            c_in     = h_ff[2];
            d_in     = h_ff[3];
            e_in     = h_ff[4];
            round_in = '0;
         end
      end
   end

   // Select the digest word on the result channel
   always_comb begin
      unique case (word_ff)
         3'd0:    rsp_tdata = h_ff[0];
         3'd1:    rsp_tdata = h_ff[1];
         3'd2:    rsp_tdata = h_ff[2];
         3'd3:    rsp_tdata = h_ff[3];
         3'd4:    rsp_tdata = h_ff[4];
         default: rsp_tdata = '0;
      endcase
      rsp_tuser = word_ff;
      rsp_tlast = (word_ff == 3'(NUM_WORDS - 1));
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         bit_count_ff <= '0;
         h_ff         <= H_INIT;
         round_ff     <= '0;
         pad_ff       <= 1'b0;
         first_ff     <= 1'b0;
         len_ff       <= 1'b0;
         word_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bit_count_ff <= bit_count_in;
         h_ff         <= h_in;
         round_ff     <= round_in;
         pad_ff       <= pad_in;
         first_ff     <= first_in;
         len_ff       <= len_in;
         word_ff      <= word_in;
      end
   end

   // Block buffer and working words
   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

   // Checks
   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while digest is presented");

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff < 7'(NUM_ROUNDS)))
      else $error("round counter out of range");

   a_block_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND || state_ff == ST_UPDATE) |-> (pos_ff == 6'd0))
      else $error("compression started on a partial block");

   a_out_after_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (pad_ff && len_ff && !first_ff))
      else $error("digest presented before length was appended");

   a_word_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (word_ff < 3'(NUM_WORDS)))
      else $error("digest word index out of range");

endmodule
